/* hw/rtl/sti_pkg.sv */
// Shared widths, codes and defaults of the spectrum table interpolator.
`default_nettype none

package sti_pkg;

    localparam int WL_W            = 32;             // wavelength, unsigned Q16.16
    localparam int INT_W           = 31;             // stored intensity, unsigned Q15.16
    localparam int PROD_W          = WL_W + INT_W;   // dx * |dy|
    localparam int TABLE_DEPTH_DEF = 64;

    // request opcodes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_INTERP = 2'd1;
    localparam logic [1:0] OP_SPAN   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

endpackage

`default_nettype wire

/* hw/rtl/sti_div.sv */
// Restoring divider, one quotient bit per cycle, for the interpolation offset.
`default_nettype none

module sti_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sti_pkg::PROD_W-1:0]    i_dividend,
    input  wire logic [sti_pkg::WL_W-1:0]      i_divisor,
    output logic                               o_done,
    output logic [sti_pkg::INT_W-1:0]          o_quotient
);

    localparam int CNT_W = $clog2(sti_pkg::INT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(sti_pkg::INT_W - 1);

    // quotient is known to fit INT_W bits, so the top WL_W bits of the
    // dividend start below the divisor and serve as the first remainder
    logic [sti_pkg::WL_W-1:0]  r_rem;
    logic [sti_pkg::WL_W-1:0]  r_div;
    logic [sti_pkg::INT_W-1:0] r_low;
    logic [sti_pkg::INT_W-1:0] r_q;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [sti_pkg::WL_W:0]    w_trial;
    logic [sti_pkg::WL_W:0]    w_diff;
    logic                      w_ge;

    always_comb begin
        w_trial = {r_rem, r_low[sti_pkg::INT_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[sti_pkg::PROD_W-1:sti_pkg::INT_W];
            r_low <= i_dividend[sti_pkg::INT_W-1:0];
            r_div <= i_divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[sti_pkg::WL_W-1:0] : w_trial[sti_pkg::WL_W-1:0];
            r_low <= {r_low[sti_pkg::INT_W-2:0], 1'b0};
            r_q   <= {r_q[sti_pkg::INT_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

    // remainder stays below the divisor through every step
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("divider remainder reached divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");

endmodule

`default_nettype wire

/* hw/rtl/spectrum_table_interpolator.sv */
// Top level: point table, binary search sequencer and linear interpolation.
`default_nettype none

// Holds up to TABLE_DEPTH (wavelength, intensity) points, wavelength unsigned
// Q16.16 and intensity unsigned Q15.16, loaded in strictly rising wavelength
// order; a bad load empties the table and every later load is refused until
// one marked first_entry. Each request gives exactly one result. Loads, span
// checks, out-of-range queries, queries at the first point and unknown opcodes
// are accepted and then moved into the output register. An interpolation walks
// a binary search over the point memory, each probe a registered read and then
// a compare, at most log2(points)+1 probes; it then reads the two bracketing
// points and forms the differences, multiplies, starts the bit-serial divider,
// waits for its quotient and done, and moves the result to the output register.
// Requests are taken only while the sequencer is idle; a finished result may
// still sit in the output register while the next request is accepted, and a
// result held by a stalled receiver keeps the sequencer in its output state.
// The point memory needs no clearing pass after reset: only entries written
// since the last table start are read, and the first point and the last
// wavelength are kept in registers.

module spectrum_table_interpolator #(
    parameter int TABLE_DEPTH = sti_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_op,
    input  wire logic                        i_first_entry,
    input  wire logic [sti_pkg::WL_W-1:0]    i_wavelength,
    input  wire logic [sti_pkg::WL_W-1:0]    i_wavelength_high,
    input  wire logic signed [31:0]          i_intensity_in,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [1:0]                       o_status,
    output logic [sti_pkg::INT_W-1:0]        o_intensity,
    output logic                             o_in_range
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PROBE    = 4'd1;
    localparam logic [3:0] S_CMP      = 4'd2;
    localparam logic [3:0] S_GET_I    = 4'd3;
    localparam logic [3:0] S_GET_A    = 4'd4;
    localparam logic [3:0] S_MUL      = 4'd5;
    localparam logic [3:0] S_DIV_GO   = 4'd6;
    localparam logic [3:0] S_DIV_WAIT = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    // point memory
    logic [sti_pkg::WL_W-1:0]  mem_wl  [TABLE_DEPTH];
    logic [sti_pkg::INT_W-1:0] mem_int [TABLE_DEPTH];
    logic [sti_pkg::WL_W-1:0]  r_rd_wl;
    logic [sti_pkg::INT_W-1:0] r_rd_int;
    logic [AW-1:0]             w_rd_addr;
    logic                      w_wr_en;
    logic [AW-1:0]             w_wr_addr;

    // table state
    logic [CW-1:0]             r_count;
    logic [sti_pkg::WL_W-1:0]  r_prev_wl;     // also the last point's wavelength
    logic                      r_failed;
    logic [sti_pkg::WL_W-1:0]  r_first_wl;
    logic [sti_pkg::INT_W-1:0] r_first_int;

    // sequencer and datapath
    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic [sti_pkg::WL_W-1:0]  r_wl;
    logic [CW-1:0]             r_lo;
    logic [CW-1:0]             r_hi;
    logic [AW-1:0]             r_mid;
    logic [sti_pkg::WL_W-1:0]  r_wi;
    logic [sti_pkg::INT_W-1:0] r_ii;
    logic [sti_pkg::INT_W-1:0] r_ia;
    logic [sti_pkg::WL_W-1:0]  r_dx;
    logic [sti_pkg::WL_W-1:0]  r_gap;
    logic [sti_pkg::INT_W-1:0] r_mag;
    logic                      r_dec;
    logic [sti_pkg::PROD_W-1:0] r_prod;

    // pending result
    logic [1:0]                r_res_status;
    logic [sti_pkg::INT_W-1:0] r_res_int;
    logic                      r_res_range;

    // output register
    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic [sti_pkg::INT_W-1:0] r_out_int;
    logic                      r_out_range;

    logic                      w_accept;
    logic [CW-1:0]             w_mid_full;
    logic [CW-1:0]             w_eff_count;
    logic                      w_eff_failed;
    logic [sti_pkg::WL_W-1:0]  w_eff_prev;
    logic                      w_reject;
    logic                      w_in_lo;
    logic                      w_in_hi;
    logic                      w_out_free;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [sti_pkg::INT_W-1:0] w_quot;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // first_entry clears the table before the point is judged
    always_comb begin
        w_eff_count  = i_first_entry ? '0   : r_count;
        w_eff_failed = i_first_entry ? 1'b0 : r_failed;
        w_eff_prev   = i_first_entry ? '0   : r_prev_wl;
        w_reject     = w_eff_failed || (i_wavelength <= w_eff_prev) ||
                       i_intensity_in[31] || (w_eff_count >= DEPTH_C);
        w_in_lo      = (r_count != '0) && (r_first_wl <= i_wavelength) &&
                       (i_wavelength <= r_prev_wl);
        w_in_hi      = (r_count != '0) && (r_first_wl <= i_wavelength_high) &&
                       (i_wavelength_high <= r_prev_wl);
        w_mid_full   = r_lo + ((r_hi - r_lo) >> 1);
        w_wr_en      = w_accept && (i_op == sti_pkg::OP_LOAD) && !w_reject;
        w_wr_addr    = w_eff_count[AW-1:0];
    end

    always_comb begin
        case (r_state)
            S_PROBE: w_rd_addr = (r_lo < r_hi) ? w_mid_full[AW-1:0] : r_lo[AW-1:0];
            S_GET_I: w_rd_addr = r_lo[AW-1:0] - 1'b1;
            default: w_rd_addr = r_lo[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_wl[w_wr_addr]  <= i_wavelength;
            mem_int[w_wr_addr] <= i_intensity_in[sti_pkg::INT_W-1:0];
        end
        r_rd_wl  <= mem_wl[w_rd_addr];
        r_rd_int <= mem_int[w_rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((i_op == sti_pkg::OP_INTERP) && w_in_lo &&
                        (i_wavelength != r_first_wl)) begin
                        n_state = S_PROBE;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_PROBE:    n_state = (r_lo < r_hi) ? S_CMP : S_GET_I;
            S_CMP:      n_state = S_PROBE;
            S_GET_I:    n_state = S_GET_A;
            S_GET_A:    n_state = S_MUL;
            S_MUL:      n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: n_state = w_div_done ? S_OUT : S_DIV_WAIT;
            S_OUT:      n_state = w_out_free ? S_IDLE : S_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_prev_wl   <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && (i_op == sti_pkg::OP_LOAD)) begin
                if (w_reject) begin
                    r_count   <= '0;
                    r_failed  <= 1'b1;
                    r_prev_wl <= w_eff_prev;
                end else begin
                    r_count   <= w_eff_count + 1'b1;
                    r_failed  <= 1'b0;
                    r_prev_wl <= i_wavelength;
                end
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_wl         <= i_wavelength;
                    r_lo         <= '0;
                    r_hi         <= r_count;
                    r_res_status <= sti_pkg::ST_RANGE;
                    r_res_int    <= '0;
                    r_res_range  <= 1'b0;
                    case (i_op)
                        sti_pkg::OP_LOAD: begin
                            if (w_reject) begin
                                r_res_status <= sti_pkg::ST_REJECT;
                            end else begin
                                r_res_status <= sti_pkg::ST_OK;
                                if (w_eff_count == '0) begin
                                    r_first_wl  <= i_wavelength;
                                    r_first_int <= i_intensity_in[sti_pkg::INT_W-1:0];
                                end
                            end
                        end
                        sti_pkg::OP_INTERP: begin
                            if (w_in_lo) begin
                                r_res_status <= sti_pkg::ST_OK;
                                r_res_range  <= 1'b1;
                                // query at the first point: that point's intensity
                                r_res_int    <= r_first_int;
                            end
                        end
                        sti_pkg::OP_SPAN: begin
                            if (w_in_lo && w_in_hi) begin
                                r_res_status <= sti_pkg::ST_OK;
                                r_res_range  <= 1'b1;
                            end
                        end
                        default: begin
                            r_res_status <= sti_pkg::ST_RANGE;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                r_mid <= w_mid_full[AW-1:0];
            end
            S_CMP: begin
                if (r_rd_wl < r_wl) begin
                    r_lo <= CW'(r_mid) + 1'b1;
                end else begin
                    r_hi <= CW'(r_mid);
                end
            end
            S_GET_I: begin
                r_wi <= r_rd_wl;
                r_ii <= r_rd_int;
            end
            S_GET_A: begin
                r_ia  <= r_rd_int;
                r_dx  <= r_wl - r_rd_wl;
                r_gap <= r_wi - r_rd_wl;
                r_dec <= (r_ii < r_rd_int);
                r_mag <= (r_ii >= r_rd_int) ? (r_ii - r_rd_int) : (r_rd_int - r_ii);
            end
            S_MUL: begin
                r_prod <= r_dx * r_mag;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    r_res_int <= r_dec ? (r_ia - w_quot) : (r_ia + w_quot);
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out_status <= r_res_status;
                    r_out_int    <= r_res_int;
                    r_out_range  <= r_res_range;
                end
            end
            default: begin
                r_mid <= r_mid;
            end
        endcase
    end

    assign w_div_start = (r_state == S_DIV_GO);

    sti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_gap),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_intensity = r_out_int;
    assign o_in_range  = r_out_range;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("point count beyond table depth");

    a_failed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> (r_count == '0))
        else $error("failed table not empty");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PROBE) || (r_state == S_CMP)) |-> (r_lo <= r_hi))
        else $error("search bounds crossed");

    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV_WAIT) && w_div_done) |-> (w_quot <= r_mag))
        else $error("interpolation offset beyond intensity step");

endmodule

`default_nettype wire

/* dv/tb_spectrum_table_interpolator.sv */
// Self-checking testbench for the spectrum table interpolator: loads, queries, span checks.
`timescale 1ns / 100ps

module tb_spectrum_table_interpolator;

    localparam int         DEPTH        = sti_pkg::TABLE_DEPTH_DEF;
    localparam logic [1:0] OP_UNUSED    = 2'd3;         // undefined opcode, answered as out of range
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         DRAIN_CYCLES = 120;          // > one full interpolation
    localparam int         PRINT_CAP    = 40;

    localparam logic [1:0] ALL_OPS [4] = '{sti_pkg::OP_LOAD, sti_pkg::OP_INTERP,
                                           sti_pkg::OP_SPAN, OP_UNUSED};

    // one awaited result, with the request it answers kept for messages
    typedef struct packed {
        logic [1:0]                status;
        logic [sti_pkg::INT_W-1:0] intensity;
        logic                      in_range;
        logic [1:0]                op;
        logic [sti_pkg::WL_W-1:0]  wavelength;
    } t_awaited_result;

    // ------------------------------------------------------------------
    // clock, reset and block ports; every input known from time zero
    // ------------------------------------------------------------------
    logic                      i_clk             = 1'b0;
    logic                      i_rst_n           = 1'b0;
    logic                      i_in_valid        = 1'b0;
    logic [1:0]                i_op              = sti_pkg::OP_LOAD;
    logic                      i_first_entry     = 1'b0;
    logic [sti_pkg::WL_W-1:0]  i_wavelength      = '0;
    logic [sti_pkg::WL_W-1:0]  i_wavelength_high = '0;
    logic signed [31:0]        i_intensity_in    = '0;
    logic                      i_out_ready       = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [1:0]                o_status;
    logic [sti_pkg::INT_W-1:0] o_intensity;
    logic                      o_in_range;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    spectrum_table_interpolator #(
        .TABLE_DEPTH (DEPTH)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_first_entry     (i_first_entry),
        .i_wavelength      (i_wavelength),
        .i_wavelength_high (i_wavelength_high),
        .i_intensity_in    (i_intensity_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_intensity       (o_intensity),
        .o_in_range        (o_in_range)
    );

    // ------------------------------------------------------------------
    // run bookkeeping
    // ------------------------------------------------------------------
    t_awaited_result awaited_results[$];
    int unsigned     requests_sent   = 0;
    int unsigned     results_checked = 0;
    int unsigned     interp_hits     = 0;
    int unsigned     loads_refused   = 0;
    int unsigned     range_misses    = 0;
    int unsigned     mismatch_count  = 0;
    int unsigned     cycle_count     = 0;
    int unsigned     send_idle_pct   = 0;   // chance per cycle that the sender holds back
    int unsigned     out_stall_pct   = 0;   // chance per cycle that the receiver stalls

    // ------------------------------------------------------------------
    // shadow of the point table, updated as each request is accepted
    // ------------------------------------------------------------------
    logic [sti_pkg::WL_W-1:0]  tab_wl  [DEPTH];
    logic [sti_pkg::INT_W-1:0] tab_int [DEPTH];
    int unsigned               tab_count      = 0;
    logic [sti_pkg::WL_W-1:0]  last_loaded_wl = '0;
    bit                        table_broken   = 1'b0;

    function automatic bit wl_in_table(input logic [sti_pkg::WL_W-1:0] q);
        if (tab_count == 0)
            return 1'b0;
        return (tab_wl[0] <= q) && (q <= tab_wl[tab_count-1]);
    endfunction

    // Lower-bound search, then a straight line between the bracketing points.
    // The offset is truncated towards zero so it never overshoots either end.
    function automatic logic [sti_pkg::INT_W-1:0] interpolated_intensity(
            input logic [sti_pkg::WL_W-1:0] q);
        int unsigned               lo;
        int unsigned               hi;
        int unsigned               mid;
        logic [sti_pkg::WL_W-1:0]  dx32;
        logic [sti_pkg::WL_W-1:0]  gap32;
        logic [sti_pkg::INT_W-1:0] ia;
        logic [sti_pkg::INT_W-1:0] ib;
        logic [sti_pkg::INT_W-1:0] dy_mag;
        logic [63:0]               offset;
        lo = 0;
        hi = tab_count;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (tab_wl[mid] < q)
                lo = mid + 1;
            else
                hi = mid;
        end
        // exactly on the first point: no lower neighbour to blend with
        if (lo == 0 || lo >= tab_count)
            return tab_int[0];
        ia     = tab_int[lo-1];
        ib     = tab_int[lo];
        dx32   = q - tab_wl[lo-1];
        gap32  = tab_wl[lo] - tab_wl[lo-1];
        dy_mag = (ib >= ia) ? ib - ia : ia - ib;
        offset = ({32'd0, dx32} * {33'd0, dy_mag}) / {32'd0, gap32};
        if (ib >= ia)
            return sti_pkg::INT_W'({33'd0, ia} + offset);
        return sti_pkg::INT_W'({33'd0, ia} - offset);
    endfunction

    // Applies one request to the shadow table and gives the answer it must draw.
    function automatic t_awaited_result table_response(input logic [1:0] op,
                                                       input logic first,
                                                       input logic [sti_pkg::WL_W-1:0] wl,
                                                       input logic [sti_pkg::WL_W-1:0] wl_hi,
                                                       input logic [31:0] inten);
        t_awaited_result r;
        r.status     = sti_pkg::ST_RANGE;
        r.intensity  = '0;
        r.in_range   = 1'b0;
        r.op         = op;
        r.wavelength = wl;
        case (op)
            sti_pkg::OP_LOAD: begin
                if (first) begin
                    tab_count      = 0;
                    table_broken   = 1'b0;
                    last_loaded_wl = '0;
                end
                if (table_broken || wl <= last_loaded_wl || inten[31] ||
                    tab_count >= DEPTH) begin
                    tab_count    = 0;
                    table_broken = 1'b1;
                    r.status     = sti_pkg::ST_REJECT;
                end else begin
                    tab_wl[tab_count]  = wl;
                    tab_int[tab_count] = inten[sti_pkg::INT_W-1:0];
                    tab_count++;
                    last_loaded_wl = wl;
                    r.status       = sti_pkg::ST_OK;
                end
            end
            sti_pkg::OP_INTERP: begin
                if (wl_in_table(wl)) begin
                    r.intensity = interpolated_intensity(wl);
                    r.status    = sti_pkg::ST_OK;
                    r.in_range  = 1'b1;
                end
            end
            sti_pkg::OP_SPAN: begin
                // ends tested separately, so a reversed span still passes
                if (wl_in_table(wl) && wl_in_table(wl_hi)) begin
                    r.status   = sti_pkg::ST_OK;
                    r.in_range = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side: drive at the falling edge, accept at the rising edge.
    // Valid is left high after acceptance; the next call either reloads the
    // payload or drops valid for an idle cycle, never both in one step.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [1:0] op, input logic first,
                                input logic [sti_pkg::WL_W-1:0] wl,
                                input logic [sti_pkg::WL_W-1:0] wl_hi,
                                input logic [31:0] inten);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_op              <= op;
        i_first_entry     <= first;
        i_wavelength      <= wl;
        i_wavelength_high <= wl_hi;
        i_intensity_in    <= inten;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        awaited_results.push_back(table_response(op, first, wl, wl_hi, inten));
        requests_sent++;
    endtask

    // result side stalls at random
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want, input logic [1:0] op,
                                   input logic [sti_pkg::WL_W-1:0] wl);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH %s: got %h want %h (op %0d, wavelength %h, cycle %0d)",
                     what, got, want, op, wl, cycle_count);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_awaited_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with no request outstanding", 32'(o_status), '0,
                                OP_UNUSED, '0);
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status),
                                    want.op, want.wavelength);
                if (o_intensity !== want.intensity)
                    report_mismatch("intensity", 32'(o_intensity), 32'(want.intensity),
                                    want.op, want.wavelength);
                if (o_in_range !== want.in_range)
                    report_mismatch("in_range", 32'(o_in_range), 32'(want.in_range),
                                    want.op, want.wavelength);
                results_checked++;
                if (want.op == sti_pkg::OP_INTERP && want.status == sti_pkg::ST_OK)
                    interp_hits++;
                if (want.status == sti_pkg::ST_REJECT)
                    loads_refused++;
                if (want.status == sti_pkg::ST_RANGE)
                    range_misses++;
            end
        end
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, awaited_results.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // a wavelength on point idx or somewhere up to the next point
    function automatic logic [sti_pkg::WL_W-1:0] point_or_between(input int unsigned idx);
        logic [sti_pkg::WL_W-1:0] gap;
        if (idx + 1 >= tab_count)
            return tab_wl[idx];
        gap = tab_wl[idx+1] - tab_wl[idx];
        return tab_wl[idx] + $urandom_range(0, gap);
    endfunction

    // one interpolation or span check, mostly aimed inside the current table
    task automatic send_table_query();
        int unsigned              a;
        int unsigned              b;
        logic [sti_pkg::WL_W-1:0] q;
        if (tab_count == 0) begin
            send_request(ALL_OPS[$urandom_range(1, 2)], 1'($urandom_range(1)), $urandom(),
                         $urandom(), $urandom());
        end else begin
            a = $urandom_range(0, tab_count - 1);
            b = $urandom_range(0, tab_count - 1);
            case ($urandom_range(0, 5))
                0:       q = tab_wl[a];
                1, 2:    q = point_or_between(a);
                3:       q = $urandom();
                default: q = point_or_between(a);
            endcase
            if ($urandom_range(99) < 60)
                send_request(sti_pkg::OP_INTERP, 1'($urandom_range(1)), q, $urandom(),
                             $urandom());
            else if ($urandom_range(99) < 70)
                send_request(sti_pkg::OP_SPAN, 1'($urandom_range(1)), q, point_or_between(b),
                             $urandom());
            else
                send_request(sti_pkg::OP_SPAN, 1'($urandom_range(1)), q, $urandom(),
                             $urandom());
        end
    endtask

    // Builds a fresh table of rising points with random content, sometimes
    // broken part way, then queries it.
    task automatic run_table_sequence();
        int unsigned              n_points;
        int unsigned              bad_at;
        int unsigned              n_queries;
        logic [sti_pkg::WL_W-1:0] wl;
        logic [sti_pkg::WL_W-1:0] step_max;
        logic [31:0]              inten;
        logic                     first;
        n_points  = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, DEPTH);
        bad_at    = ($urandom_range(99) < 12) ? $urandom_range(0, n_points - 1) : DEPTH;
        wl        = $urandom_range(0, 32'hFFFF_FF00);
        step_max  = (32'hFFFF_FFFF - wl) / n_points;
        if ($urandom_range(99) < 30 && step_max > 16)
            step_max = 16;                      // tight gaps, small divisors
        inten     = $urandom() & 32'h7FFF_FFFF;
        for (int k = 0; k < n_points; k++) begin
            wl = wl + $urandom_range(1, step_max);
            case ($urandom_range(0, 3))
                0:       ;                                   // flat segment
                1:       inten = $urandom_range(0, 255);
                default: inten = $urandom() & 32'h7FFF_FFFF;
            endcase
            // now and then the first point appends to whatever is there
            first = (k == 0) && ($urandom_range(99) < 95);
            if (k == bad_at) begin
                if ($urandom_range(1))
                    send_request(sti_pkg::OP_LOAD, first, wl, $urandom(),
                                 inten | 32'h8000_0000);
                else
                    send_request(sti_pkg::OP_LOAD, k == 0,
                                 (k == 0) ? '0 : $urandom_range(0, last_loaded_wl),
                                 $urandom(), inten);
            end else begin
                send_request(sti_pkg::OP_LOAD, first, wl, $urandom(), inten);
            end
        end
        n_queries = $urandom_range(1, 6);
        for (int j = 0; j < n_queries; j++)
            send_table_query();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // nothing loaded yet: every query misses, a zero wavelength is refused
    task automatic test_empty_table();
        send_request(sti_pkg::OP_INTERP, 1'b0, '0, $urandom(), $urandom());
        send_request(sti_pkg::OP_INTERP, 1'b1, 32'hFFFF_FFFF, $urandom(), $urandom());
        send_request(sti_pkg::OP_SPAN, 1'b0, '0, 32'hFFFF_FFFF, '0);
        send_request(OP_UNUSED, 1'b1, $urandom(), $urandom(), $urandom());
        send_request(sti_pkg::OP_LOAD, 1'b0, '0, '0, '0);
    endtask

    // field extremes on a small table: first and last points, falling and
    // rising segments, a long gap, reversed and half-outside spans
    task automatic test_directed_table();
        send_request(sti_pkg::OP_LOAD, 1'b1, 32'h0001_0000, '0, 32'h7FFF_FFFF);
        send_request(sti_pkg::OP_LOAD, 1'b0, 32'h0002_0000, '0, 32'h0000_0000);
        send_request(sti_pkg::OP_LOAD, 1'b0, 32'h0003_0000, '0, 32'h0000_0100);
        send_request(sti_pkg::OP_LOAD, 1'b0, 32'hFFFF_FFFF, '0, 32'h7FFF_FFFF);
        send_request(sti_pkg::OP_INTERP, 1'b0, 32'h0001_0000, '0, '0);
        send_request(sti_pkg::OP_INTERP, 1'b0, 32'h0000_FFFF, '0, '0);
        send_request(sti_pkg::OP_INTERP, 1'b0, 32'h0001_8000, '0, '0);
        send_request(sti_pkg::OP_INTERP, 1'b0, 32'h0002_0000, '0, '0);
        send_request(sti_pkg::OP_INTERP, 1'b0, 32'h8000_0000, '0, '0);
        send_request(sti_pkg::OP_INTERP, 1'b0, 32'hFFFF_FFFF, '0, '0);
        send_request(sti_pkg::OP_SPAN, 1'b0, 32'h0003_0000, 32'h0001_0000, '0);
        send_request(sti_pkg::OP_SPAN, 1'b0, 32'h0001_0000, 32'hFFFF_FFFF, '0);
        send_request(sti_pkg::OP_SPAN, 1'b0, 32'h0000_0001, 32'h0002_0000, '0);
        send_request(OP_UNUSED, 1'b0, 32'h0002_0000, '0, '0);
    endtask

    // refusals: equal and lower wavelengths, negative intensity, loads while
    // broken, and a single-point table
    task automatic test_load_refusals();
        send_request(sti_pkg::OP_LOAD, 1'b0, 32'h0000_0010, '0, 32'h0000_0001);
        send_request(sti_pkg::OP_LOAD, 1'b1, 32'h0000_0100, '0, 32'h0000_0005);
        send_request(sti_pkg::OP_LOAD, 1'b0, 32'h0000_0100, '0, 32'h0000_0006);
        send_request(sti_pkg::OP_LOAD, 1'b0, 32'h0000_0200, '0, 32'h0000_0007);
        send_request(sti_pkg::OP_INTERP, 1'b0, 32'h0000_0100, '0, '0);
        send_request(sti_pkg::OP_LOAD, 1'b1, 32'h0000_0200, '0, 32'h8000_0000);
        send_request(sti_pkg::OP_LOAD, 1'b1, 32'h0000_0200, '0, 32'h0000_0001);
        send_request(sti_pkg::OP_LOAD, 1'b0, 32'h0000_01FF, '0, 32'h0000_0001);
        send_request(sti_pkg::OP_SPAN, 1'b0, 32'h0000_0200, 32'h0000_0200, '0);
        send_request(sti_pkg::OP_LOAD, 1'b1, 32'h0000_0300, '0, 32'h0000_1234);
        send_request(sti_pkg::OP_INTERP, 1'b0, 32'h0000_0300, '0, '0);
        send_request(sti_pkg::OP_INTERP, 1'b0, 32'h0000_0301, '0, '0);
    endtask

    // fill to depth, overflow by one, then refill with wide gaps and probe the ends
    task automatic test_table_full();
        for (int k = 0; k < DEPTH; k++)
            send_request(sti_pkg::OP_LOAD, k == 0, (k + 1) * 32'h0100_0000, $urandom(),
                         $urandom() & 32'h7FFF_FFFF);
        send_request(sti_pkg::OP_LOAD, 1'b0, 32'hF000_0000, '0, 32'h0000_0001);
        send_request(sti_pkg::OP_INTERP, 1'b0, 32'h0100_0000, '0, '0);
        for (int k = 0; k < DEPTH; k++)
            send_request(sti_pkg::OP_LOAD, k == 0, (k + 1) * 32'h03FF_FFFF, $urandom(),
                         $urandom() & 32'h7FFF_FFFF);
        send_request(sti_pkg::OP_INTERP, 1'b0, 32'h03FF_FFFF, '0, '0);
        send_request(sti_pkg::OP_INTERP, 1'b0, DEPTH * 32'h03FF_FFFF, '0, '0);
        send_request(sti_pkg::OP_INTERP, 1'b0, DEPTH * 32'h03FF_FFFF - 32'h0001_2345,
                     '0, '0);
        send_request(sti_pkg::OP_SPAN, 1'b0, DEPTH * 32'h03FF_FFFF, 32'h03FF_FFFF, '0);
    endtask

    // mostly well-formed tables with random content, a quarter pure noise
    task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct,
                                       input int unsigned stall_at);
        int unsigned stop_at;
        stop_at       = requests_sent + n_items;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_at;
        while (requests_sent < stop_at) begin
            if ($urandom_range(99) < 75)
                run_table_sequence();
            else
                send_request(ALL_OPS[$urandom_range(0, 3)], 1'($urandom_range(1)),
                             $urandom(), $urandom(), $urandom());
        end
    endtask

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_directed_table();
        test_load_refusals();
        test_table_full();

        test_random_traffic(180, 0, 0);      // back to back
        test_random_traffic(180, 88, 0);     // sparse requests
        test_random_traffic(180, 0, 88);     // slow receiver
        test_random_traffic(180, 11, 11);    // light jitter both sides

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", awaited_results.size(), '0,
                            OP_UNUSED, '0);

        $display("Checked %0d results from %0d requests in %0d cycles.",
                 results_checked, requests_sent, cycle_count);
        $display("Covered %0d in-table interpolations, %0d refused loads, %0d misses.",
                 interp_hits, loads_refused, range_misses);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
